>>> hw/rtl/bpa_pkg.sv
// shared field widths and codes of the buddy page allocator
`default_nettype none
package bpa_pkg;
    localparam int OP_W    = 1;
    localparam int COUNT_W = 13;
    localparam int PAGE_W  = 12;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOBLK = 2'd2;
endpackage
`default_nettype wire

>>> hw/rtl/bpa_if.sv
// request, response and configuration channel interfaces
`default_nettype none
interface bpa_req_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::OP_W-1:0]     operation;
    logic [bpa_pkg::COUNT_W-1:0]  request_pages;
    logic [bpa_pkg::PAGE_W-1:0]   start_page;
    modport source(output valid, output operation, output request_pages,
                   output start_page, input ready);
    modport sink(input valid, input operation, input request_pages,
                 input start_page, output ready);
endinterface

interface bpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::STAT_W-1:0]   status;
    logic [bpa_pkg::PAGE_W-1:0]   granted_page;
    logic [bpa_pkg::COUNT_W-1:0]  pages_available;
    modport source(output valid, output status, output granted_page,
                   output pages_available, input ready);
    modport sink(input valid, input status, input granted_page,
                 input pages_available, output ready);
endinterface

interface bpa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::COUNT_W-1:0]  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bpa_ram.sv
// generic single write, single read ram with registered read
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/buddy_page_allocator.sv
// buddy page allocator: sequencer over link and block-info rams
//
// Channels: i_req carries one operation per beat (allocate or free, page count,
// start page), o_rsp returns one beat per request (status, granted page, pages
// still available), i_cfg writes the managed page count.
// A request beat is taken only while the sequencer is idle. A rejected request
// goes straight to the response step. An allocation rounds the request up one
// order at a time, searches the lists from that order upward, unlinks the
// found block, pushes the upper half at each split, frees any tail and then
// finishes; a free splits the range into aligned blocks and merges each with
// its free buddies one order at a time. A push takes the steps PU1 and PU2 and
// an unlink UL0 to UL2, as every list update passes through the single write
// port of each link ram.
// After reset, and after each configuration beat, a clearing pass of
// all PAGE_SLOTS entries sweeps every ram, then the free lists are rebuilt
// greedily from the top order down; no request is taken meanwhile.
// The response sits in an output register; a stalled receiver holds it and
// the next request may be taken, but its result waits until the register
// drains. Reset is synchronous and active low.
`default_nettype none
module buddy_page_allocator #(
    parameter int PAGE_SLOTS = 4096,
    parameter int TOP_ORDER  = 12
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpa_req_if.sink    i_req,
    bpa_rsp_if.source  o_rsp,
    bpa_cfg_if.sink    i_cfg
);
    localparam int AW  = $clog2(PAGE_SLOTS);
    localparam int LW  = AW + 1;
    localparam int OW  = $clog2(TOP_ORDER + 2);
    localparam int HW  = $clog2(TOP_ORDER + 1);
    localparam int IW  = OW + 1;
    localparam int DW0 = (LW > TOP_ORDER + 2) ? LW : TOP_ORDER + 2;
    localparam int DW  = ((DW0 > 14) ? DW0 : 14) + 1;
    localparam int MGR = (PAGE_SLOTS < 4096) ? PAGE_SLOTS : 4096;

    localparam logic [LW-1:0] NO_LINK = LW'(PAGE_SLOTS);
    localparam logic [DW-1:0] PS_D    = DW'(PAGE_SLOTS);
    localparam logic [DW-1:0] TOPSZ_D = DW'(1) << TOP_ORDER;
    localparam logic [OW-1:0] TOP_O   = OW'(TOP_ORDER);
    localparam logic [AW-1:0] LAST_IX = AW'(PAGE_SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLR, S_RB, S_RB_ADV, S_IDLE, S_AL_ORD, S_TK1, S_TK2,
        S_FR_A, S_FR_A2, S_FR_B, S_FR_B2,
        S_FB0, S_FB1, S_FB2, S_FB3, S_FB_END,
        S_PU1, S_PU2, S_UL0, S_UL1, S_UL2, S_FIN
    } t_state;

    t_state r_state, r_ret, r_fbret, r_frret;

    logic [DW-1:0] r_managed, r_avail, r_n, r_s;
    logic [DW-1:0] r_rn, r_rs, r_rsz;
    logic [DW-1:0] r_pg, r_sz, r_b, r_apg;
    logic [DW-1:0] r_tp, r_tsz, r_asz;
    logic [OW-1:0] r_rord, r_ord, r_aord, r_c, r_tord;
    logic [LW-1:0] r_h;
    logic [LW-1:0] r_head [TOP_ORDER+1];
    logic [AW-1:0] r_idx;
    logic          r_op;
    logic [bpa_pkg::STAT_W-1:0] r_status;

    logic                         r_ov;
    logic [bpa_pkg::STAT_W-1:0]   r_ost;
    logic [bpa_pkg::PAGE_W-1:0]   r_ogp;
    logic [bpa_pkg::COUNT_W-1:0]  r_oav;

    // ram ports
    logic          nx_we, pv_we, in_we;
    logic [AW-1:0] nx_wa, pv_wa, in_wa, nx_ra, pv_ra, in_ra;
    logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic [IW-1:0] in_wd, in_rd;

    logic [LW-1:0] head_cur;
    logic [DW-1:0] buddy, split_q, cfg_v, new_avail, free_sum;

    assign head_cur = r_head[r_aord[HW-1:0]];
    assign buddy    = r_pg ^ r_sz;
    assign split_q  = r_tp + (r_tsz >> 1);
    assign cfg_v    = DW'(i_cfg.data);
    assign free_sum = r_avail + r_n;

    // available count after a finished operation
    always_comb begin
        new_avail = r_avail;
        if (r_status == bpa_pkg::ST_DONE) begin
            if (r_op == bpa_pkg::OP_ALLOC) begin
                new_avail = r_avail - r_n;
            end else begin
                new_avail = (free_sum > r_managed) ? r_managed : free_sum;
            end
        end
    end

    bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));
    bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_SLOTS)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd));
    bpa_ram #(.WIDTH(IW), .DEPTH(PAGE_SLOTS)) u_info (
        .i_clk(i_clk), .i_we(in_we), .i_waddr(in_wa), .i_wdata(in_wd),
        .i_raddr(in_ra), .o_rdata(in_rd));

    // ram control per sequencer step
    always_comb begin
        nx_we = 1'b0;  nx_wa = r_apg[AW-1:0]; nx_wd = NO_LINK;
        pv_we = 1'b0;  pv_wa = r_apg[AW-1:0]; pv_wd = NO_LINK;
        in_we = 1'b0;  in_wa = r_pg[AW-1:0];  in_wd = '0;
        nx_ra = r_apg[AW-1:0];
        pv_ra = r_apg[AW-1:0];
        in_ra = buddy[AW-1:0];
        case (r_state)
            S_CLR: begin
                nx_we = 1'b1; nx_wa = r_idx;
                pv_we = 1'b1; pv_wa = r_idx;
                in_we = 1'b1; in_wa = r_idx;
            end
            S_RB: begin
                if (r_rn != '0 && r_rn >= r_rsz && r_rs < PS_D) begin
                    in_we = 1'b1;
                    in_wa = r_rs[AW-1:0];
                    in_wd = {1'b1, r_rord};
                end
            end
            S_PU1: begin
                nx_we = 1'b1; nx_wd = head_cur;
                pv_we = 1'b1;
            end
            S_PU2: begin
                if (r_h < NO_LINK) begin
                    pv_we = 1'b1;
                    pv_wa = r_h[AW-1:0];
                    pv_wd = r_apg[LW-1:0];
                end
            end
            S_UL1: begin
                if (pv_rd < NO_LINK) begin
                    nx_we = 1'b1; nx_wa = pv_rd[AW-1:0]; nx_wd = nx_rd;
                end
                if (nx_rd < NO_LINK) begin
                    pv_we = 1'b1; pv_wa = nx_rd[AW-1:0]; pv_wd = pv_rd;
                end
            end
            S_UL2: begin
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            S_FB0: begin
                in_we = (r_pg < PS_D);
            end
            S_FB3: begin
                in_we = 1'b1;
                in_wa = r_b[AW-1:0];
            end
            S_FB_END: begin
                in_we = 1'b1;
                in_wd = {1'b1, r_ord};
            end
            S_TK2: begin
                if (r_c > r_tord) begin
                    if (split_q < PS_D) begin
                        in_we = 1'b1;
                        in_wa = split_q[AW-1:0];
                        in_wd = {1'b1, r_c - OW'(1)};
                    end
                end else begin
                    in_we = 1'b1;
                    in_wa = r_tp[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE) && !i_req.valid;

    assign o_rsp.valid           = r_ov;
    assign o_rsp.status          = r_ost;
    assign o_rsp.granted_page    = r_ogp;
    assign o_rsp.pages_available = r_oav;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_managed <= DW'(MGR);
            r_ov      <= 1'b0;
        end else begin
            if (r_ov && o_rsp.ready && r_state != S_FIN) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_tp     <= '0;
                    if (i_req.valid) begin
                        r_op <= i_req.operation;
                        r_n  <= DW'(i_req.request_pages);
                        r_s  <= DW'(i_req.start_page);
                        if (i_req.operation == bpa_pkg::OP_ALLOC) begin
                            if (i_req.request_pages == '0
                                || DW'(i_req.request_pages) > r_avail
                                || DW'(i_req.request_pages) > TOPSZ_D) begin
                                r_status <= bpa_pkg::ST_BAD;
                                r_state  <= S_FIN;
                            end else begin
                                r_status <= bpa_pkg::ST_DONE;
                                r_tord  <= '0;
                                r_asz   <= DW'(1);
                                r_state <= S_AL_ORD;
                            end
                        end else begin
                            if (i_req.request_pages == '0
                                || DW'(i_req.start_page) + DW'(i_req.request_pages)
                                   > r_managed) begin
                                r_status <= bpa_pkg::ST_BAD;
                                r_state  <= S_FIN;
                            end else begin
                                r_status <= bpa_pkg::ST_DONE;
                                r_rs    <= DW'(i_req.start_page);
                                r_rn    <= DW'(i_req.request_pages);
                                r_rord  <= '0;
                                r_rsz   <= DW'(1);
                                r_frret <= S_FIN;
                                r_state <= S_FR_A;
                            end
                        end
                    end else if (i_cfg.valid) begin
                        r_managed <= (cfg_v > PS_D) ? PS_D : cfg_v;
                        r_idx     <= '0;
                        r_state   <= S_CLR;
                    end
                end
                // clearing pass over all rams and heads
                S_CLR: begin
                    for (int k = 0; k <= TOP_ORDER; k++) begin
                        r_head[k] <= NO_LINK;
                    end
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == LAST_IX) begin
                        r_rn    <= r_managed;
                        r_rs    <= '0;
                        r_rord  <= TOP_O;
                        r_rsz   <= TOPSZ_D;
                        r_avail <= r_managed;
                        r_state <= S_RB;
                    end
                end
                // greedy rebuild from the top order down
                S_RB: begin
                    if (r_rn == '0) begin
                        r_state <= S_IDLE;
                    end else if (r_rn >= r_rsz && r_rs < PS_D) begin
                        r_apg   <= r_rs;
                        r_aord  <= r_rord;
                        r_ret   <= S_RB_ADV;
                        r_state <= S_PU1;
                    end else if (r_rn < r_rsz) begin
                        r_rord <= r_rord - OW'(1);
                        r_rsz  <= r_rsz >> 1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RB_ADV: begin
                    r_rn    <= r_rn - r_rsz;
                    r_rs    <= r_rs + r_rsz;
                    r_state <= S_RB;
                end
                // round the request up to a power of two
                S_AL_ORD: begin
                    if (r_asz < r_n) begin
                        r_tord <= r_tord + OW'(1);
                        r_asz  <= r_asz << 1;
                    end else begin
                        r_c     <= r_tord;
                        r_aord  <= r_tord;
                        r_tsz   <= r_asz;
                        r_state <= S_TK1;
                    end
                end
                // search the smallest non-empty list
                S_TK1: begin
                    if (r_c > TOP_O) begin
                        r_status <= bpa_pkg::ST_NOBLK;
                        r_state  <= S_FIN;
                    end else if (head_cur < NO_LINK) begin
                        r_tp    <= DW'(head_cur);
                        r_apg   <= DW'(head_cur);
                        r_ret   <= S_TK2;
                        r_state <= S_UL0;
                    end else begin
                        r_c    <= r_c + OW'(1);
                        r_aord <= r_c + OW'(1);
                        r_tsz  <= r_tsz << 1;
                    end
                end
                // split down, pushing upper halves, then free the tail
                S_TK2: begin
                    if (r_c > r_tord) begin
                        r_c   <= r_c - OW'(1);
                        r_tsz <= r_tsz >> 1;
                        if (split_q < PS_D) begin
                            r_apg   <= split_q;
                            r_aord  <= r_c - OW'(1);
                            r_ret   <= S_TK2;
                            r_state <= S_PU1;
                        end
                    end else if (r_n != r_asz) begin
                        r_rs    <= r_tp + r_n;
                        r_rn    <= r_asz - r_n;
                        r_rord  <= '0;
                        r_rsz   <= DW'(1);
                        r_frret <= S_FIN;
                        r_state <= S_FR_A;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                // range free, rising alignment phase
                S_FR_A: begin
                    if (r_rord < TOP_O && r_rn >= r_rsz) begin
                        if ((r_rs & r_rsz) != '0) begin
                            r_pg    <= r_rs;
                            r_ord   <= r_rord;
                            r_sz    <= r_rsz;
                            r_fbret <= S_FR_A2;
                            r_state <= S_FB0;
                        end else begin
                            r_rord <= r_rord + OW'(1);
                            r_rsz  <= r_rsz << 1;
                        end
                    end else begin
                        r_state <= S_FR_B;
                    end
                end
                S_FR_A2: begin
                    r_rs    <= r_rs + r_rsz;
                    r_rn    <= r_rn - r_rsz;
                    r_rord  <= r_rord + OW'(1);
                    r_rsz   <= r_rsz << 1;
                    r_state <= S_FR_A;
                end
                // range free, falling phase
                S_FR_B: begin
                    if (r_rn == '0) begin
                        r_state <= r_frret;
                    end else if (r_rn < r_rsz) begin
                        r_rord <= r_rord - OW'(1);
                        r_rsz  <= r_rsz >> 1;
                    end else begin
                        r_pg    <= r_rs;
                        r_ord   <= r_rord;
                        r_sz    <= r_rsz;
                        r_fbret <= S_FR_B2;
                        r_state <= S_FB0;
                    end
                end
                S_FR_B2: begin
                    r_rs    <= r_rs + r_rsz;
                    r_rn    <= r_rn - r_rsz;
                    r_state <= S_FR_B;
                end
                // block free with buddy merging
                S_FB0: begin
                    r_state <= (r_pg < PS_D) ? S_FB1 : r_fbret;
                end
                S_FB1: begin
                    if (r_ord < TOP_O && buddy < r_managed && buddy < PS_D) begin
                        r_b     <= buddy;
                        r_state <= S_FB2;
                    end else begin
                        r_state <= S_FB_END;
                    end
                end
                S_FB2: begin
                    if (!in_rd[IW-1] || in_rd[OW-1:0] != r_ord) begin
                        r_state <= S_FB_END;
                    end else begin
                        r_apg   <= r_b;
                        r_aord  <= r_ord;
                        r_ret   <= S_FB3;
                        r_state <= S_UL0;
                    end
                end
                S_FB3: begin
                    r_pg    <= r_pg & r_b;
                    r_ord   <= r_ord + OW'(1);
                    r_sz    <= r_sz << 1;
                    r_state <= S_FB1;
                end
                S_FB_END: begin
                    r_apg   <= r_pg;
                    r_aord  <= r_ord;
                    r_ret   <= r_fbret;
                    r_state <= S_PU1;
                end
                // push at list head
                S_PU1: begin
                    r_h <= head_cur;
                    r_head[r_aord[HW-1:0]] <= r_apg[LW-1:0];
                    r_state <= S_PU2;
                end
                S_PU2: begin
                    r_state <= r_ret;
                end
                // unlink from list
                S_UL0: begin
                    r_state <= S_UL1;
                end
                S_UL1: begin
                    if (pv_rd >= NO_LINK) begin
                        r_head[r_aord[HW-1:0]] <= nx_rd;
                    end
                    r_state <= S_UL2;
                end
                S_UL2: begin
                    r_state <= r_ret;
                end
                // load the response register
                S_FIN: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov    <= 1'b1;
                        r_ost   <= r_status;
                        r_ogp   <= (r_status == bpa_pkg::ST_DONE
                                    && r_op == bpa_pkg::OP_ALLOC)
                                   ? r_tp[bpa_pkg::PAGE_W-1:0] : '0;
                        r_oav   <= new_avail[bpa_pkg::COUNT_W-1:0];
                        r_avail <= new_avail;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/bpa_checker.sv
// port-level checks for the buddy page allocator, bound to the top level
`default_nettype none
module bpa_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_ready,
    input wire logic                          i_cfg_valid,
    input wire logic                          i_cfg_ready,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [bpa_pkg::STAT_W-1:0]    i_rsp_status,
    input wire logic [bpa_pkg::PAGE_W-1:0]    i_rsp_granted,
    input wire logic [bpa_pkg::COUNT_W-1:0]   i_rsp_avail
);
    // a failed operation never grants a page
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != bpa_pkg::ST_DONE |-> i_rsp_granted == '0)
        else $error("grant on failed operation");

    // available pages never exceed the store
    a_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_avail <= 13'd4096)
        else $error("available count out of range");

    // a configuration beat starts a rebuild that blocks requests
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready |=> !i_req_ready)
        else $error("request taken during rebuild");

    // a stalled response holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_granted) && $stable(i_rsp_avail))
        else $error("stalled response changed");
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_ready   (i_req.ready),
    .i_cfg_valid   (i_cfg.valid),
    .i_cfg_ready   (i_cfg.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_granted (o_rsp.granted_page),
    .i_rsp_avail   (o_rsp.pages_available)
);
`default_nettype wire

>>> test/tb_buddy_page_allocator.sv
// self-checking testbench for the buddy page allocator
`timescale 1ns / 1ps
`default_nettype none
module tb_buddy_page_allocator;

    localparam int SLOTS = 4096;
    localparam int TOPO  = 12;
    localparam int NONE  = SLOTS;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [bpa_pkg::OP_W-1:0]    operation;
        logic [bpa_pkg::COUNT_W-1:0] request_pages;
        logic [bpa_pkg::PAGE_W-1:0]  start_page;
    } t_req;

    typedef struct packed {
        logic [bpa_pkg::STAT_W-1:0]  status;
        logic [bpa_pkg::PAGE_W-1:0]  granted_page;
        logic [bpa_pkg::COUNT_W-1:0] pages_available;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpa_req_if req_ch();
    bpa_rsp_if rsp_ch();
    bpa_cfg_if cfg_ch();

    buddy_page_allocator uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    int unsigned pool_size;
    int unsigned head_of[TOPO+1];
    int unsigned nxt[SLOTS];
    int unsigned prv[SLOTS];
    bit          is_free[SLOTS];
    int unsigned ord_of[SLOTS];
    int unsigned avail;

    t_req pending_reqs[$];
    t_rsp awaited_rsps[$];
    int   mismatch_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    longint cycle_count = 0;

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_blk(int unsigned o, int unsigned pg);
        int unsigned h;
        h = head_of[o];
        nxt[pg] = h;
        prv[pg] = NONE;
        if (h < SLOTS) prv[h] = pg;
        head_of[o] = pg;
    endfunction

    function automatic void unlink_blk(int unsigned o, int unsigned pg);
        int unsigned nx, pv;
        nx = nxt[pg];
        pv = prv[pg];
        if (pv < SLOTS) nxt[pv] = nx;
        else head_of[o] = nx;
        if (nx < SLOTS) prv[nx] = pv;
        nxt[pg] = NONE;
        prv[pg] = NONE;
    endfunction

    // rebuild free lists greedily from the top order down
    function automatic void rebuild_lists(int unsigned value);
        int unsigned n, o, sz, pg;
        pool_size = (value > SLOTS) ? SLOTS : value;
        for (int i = 0; i <= TOPO; i++) head_of[i] = NONE;
        for (int i = 0; i < SLOTS; i++) begin
            nxt[i] = NONE;
            prv[i] = NONE;
            is_free[i] = 0;
            ord_of[i] = 0;
        end
        avail = pool_size;
        n = pool_size;
        o = TOPO;
        sz = 1 << TOPO;
        pg = 0;
        while (n != 0) begin
            while (n >= sz && pg < SLOTS) begin
                is_free[pg] = 1;
                ord_of[pg] = o;
                push_blk(o, pg);
                n -= sz;
                pg += sz;
            end
            if (n < sz) begin
                o--;
                sz >>= 1;
            end else break;
        end
    endfunction

    // release one block, merging with free buddies
    function automatic void release_blk(int unsigned pg, int unsigned o);
        int unsigned b;
        if (pg >= SLOTS) return;
        is_free[pg] = 0;
        while (o < TOPO) begin
            b = pg ^ (1 << o);
            if (b >= pool_size || b >= SLOTS || !is_free[b] || ord_of[b] != o) break;
            unlink_blk(o, b);
            is_free[b] = 0;
            pg &= b;
            o++;
        end
        ord_of[pg] = o;
        is_free[pg] = 1;
        push_blk(o, pg);
    endfunction

    function automatic void release_range(int unsigned s, int unsigned n);
        int unsigned o, sz;
        o = 0;
        sz = 1;
        while (o < TOPO && n >= sz) begin
            if ((s & sz) != 0) begin
                release_blk(s, o);
                s += sz;
                n -= sz;
            end
            o++;
            sz <<= 1;
        end
        while (n != 0) begin
            while (n < sz) begin
                o--;
                sz >>= 1;
            end
            release_blk(s, o);
            s += sz;
            n -= sz;
        end
    endfunction

    function automatic int unsigned grab_blk(int unsigned o);
        int unsigned pg, sz, q, c;
        for (c = o; c <= TOPO; c++) begin
            pg = head_of[c];
            if (pg < SLOTS) begin
                sz = 1 << c;
                unlink_blk(c, pg);
                while (c > o) begin
                    c--;
                    sz >>= 1;
                    q = pg + sz;
                    if (q < SLOTS) begin
                        ord_of[q] = c;
                        is_free[q] = 1;
                        push_blk(c, q);
                    end
                end
                is_free[pg] = 0;
                return pg;
            end
        end
        return NONE;
    endfunction

    // expected response for one request
    function automatic t_rsp predict_page_op(t_req r);
        t_rsp res;
        int unsigned n, s, o, sz, pg;
        n = r.request_pages;
        s = r.start_page;
        res.status = bpa_pkg::ST_DONE;
        res.granted_page = '0;
        if (r.operation == bpa_pkg::OP_ALLOC) begin
            if (n == 0 || n > avail || n > (1 << TOPO)) res.status = bpa_pkg::ST_BAD;
            else begin
                o = 0;
                sz = 1;
                while (sz < n) begin
                    o++;
                    sz <<= 1;
                end
                pg = grab_blk(o);
                if (pg >= SLOTS) res.status = bpa_pkg::ST_NOBLK;
                else begin
                    if (n != sz) release_range(pg + n, sz - n);
                    avail -= n;
                    res.granted_page = pg[bpa_pkg::PAGE_W-1:0];
                end
            end
        end else begin
            if (n == 0 || s + n > pool_size) res.status = bpa_pkg::ST_BAD;
            else begin
                release_range(s, n);
                avail += n;
                if (avail > pool_size) avail = pool_size;
            end
        end
        res.pages_available = avail[bpa_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_ch.ready) begin
            req_ch.valid <= 1'b1;
        end else begin
            if (req_ch.valid) begin
                awaited_rsps.push_back(predict_page_op(
                    {req_ch.operation, req_ch.request_pages, req_ch.start_page}));
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_req nx;
                nx = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.operation <= nx.operation;
                req_ch.request_pages <= nx.request_pages;
                req_ch.start_page <= nx.start_page;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_rsps.size() == 0) begin
                    report("unexpected beat", 16'd0, 16'd0);
                end else begin
                    t_rsp want;
                    want = awaited_rsps.pop_front();
                    if (rsp_ch.status !== want.status)
                        report("status", rsp_ch.status, want.status);
                    if (rsp_ch.granted_page !== want.granted_page)
                        report("granted_page", rsp_ch.granted_page, want.granted_page);
                    if (rsp_ch.pages_available !== want.pages_available)
                        report("pages_available", rsp_ch.pages_available,
                               want.pages_available);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_buddy_page_allocator: FAIL");
            $finish;
        end
    end

    function automatic t_req mk(logic [bpa_pkg::OP_W-1:0] op, int unsigned n,
                                int unsigned s);
        t_req r;
        r.operation = op;
        r.request_pages = n[bpa_pkg::COUNT_W-1:0];
        r.start_page = s[bpa_pkg::PAGE_W-1:0];
        return r;
    endfunction

    // wait until every request is sent and every response returned
    task automatic drain();
        while (pending_reqs.size() > 0 || req_ch.valid || awaited_rsps.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // write managed page count while idle
    task automatic set_pool(int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value[bpa_pkg::COUNT_W-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        rebuild_lists(value);
        cfg_ch.valid <= 1'b0;
    endtask

    // random mix, mostly small allocations and frees of ranges inside the pool
    task automatic random_phase(int count, int unsigned pool);
        int unsigned n, s;
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(8191)
                                            : $urandom_range(1, 1 << $urandom_range(6));
                pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, n, $urandom_range(4095)));
            end else if (kind < 92 && pool > 0) begin
                s = $urandom_range(pool - 1);
                n = $urandom_range(1, (pool - s > 64) ? 64 : pool - s);
                pending_reqs.push_back(mk(bpa_pkg::OP_FREE, n, s));
            end else begin
                pending_reqs.push_back(mk(($urandom_range(1) != 0) ? bpa_pkg::OP_FREE
                                                                   : bpa_pkg::OP_ALLOC,
                                          $urandom_range(8191), $urandom_range(4095)));
            end
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.operation = bpa_pkg::OP_ALLOC;
        req_ch.request_pages = '0;
        req_ch.start_page = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rebuild_lists(SLOTS);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, rejects, tail free, merges
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 0, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 4097, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 8191, 4095));
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 4096, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 1, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_FREE, 4096, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_FREE, 0, 5));
        pending_reqs.push_back(mk(bpa_pkg::OP_FREE, 2, 4095));
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 3, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 1000, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 2049, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_FREE, 3, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_FREE, 1, 4095));
        pending_reqs.push_back(mk(bpa_pkg::OP_FREE, 8191, 4095));
        drain();

        set_pool(0);
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 1, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_FREE, 1, 0));
        drain();
        set_pool(8191);
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 4096, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 1, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_FREE, 4096, 0));
        drain();
        set_pool(1);
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 1, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_ALLOC, 1, 0));
        pending_reqs.push_back(mk(bpa_pkg::OP_FREE, 1, 0));
        drain();

        // random phases with varied idling and pool sizes
        set_pool(100);
        send_idle_pct = 14;
        recv_idle_pct = 70;
        random_phase(350, 100);
        drain();
        set_pool(4096);
        send_idle_pct = 70;
        recv_idle_pct = 14;
        random_phase(350, 4096);
        drain();
        set_pool(777);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(350, 777);
        drain();

        if (mismatch_count == 0 && awaited_rsps.size() == 0)
            $display("tb_buddy_page_allocator: PASS");
        else
            $display("tb_buddy_page_allocator: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

>>> buddy_page_allocator.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_if.sv
hw/rtl/bpa_ram.sv
hw/rtl/buddy_page_allocator.sv
hw/rtl/bpa_checker.sv
test/tb_buddy_page_allocator.sv
